@@ rtl/ggc_pkg.sv @@
`timescale 1ns / 1ps

package ggc_pkg;

  // Graph size and the vertices that a 6-bit field can reach.
  localparam int MAX_VERTICES  = 64;
  localparam int FIELD_W       = 6;
  localparam int SLOTS         = 1 << FIELD_W;
  localparam int LIVE_VERTICES = (MAX_VERTICES < SLOTS) ? MAX_VERTICES : SLOTS;
  localparam int VW            = (LIVE_VERTICES > 1) ? $clog2(LIVE_VERTICES) : 1;

  // Colour set and the two-level first-free search over it.
  localparam int COLORS  = 1 << FIELD_W;
  localparam int GROUP_W = 8;
  localparam int GROUPS  = COLORS / GROUP_W;
  localparam int GIDX_W  = $clog2(GROUP_W);
  localparam int GSEL_W  = $clog2(GROUPS);

  // Stream payload widths.
  localparam int TDATA_W = 16;
  localparam int TUSER_W = 2;

  // Function codes carried on in_tuser.
  localparam logic [TUSER_W-1:0] FUNC_EDGE  = 2'd0;
  localparam logic [TUSER_W-1:0] FUNC_COLOR = 2'd1;
  localparam logic [TUSER_W-1:0] FUNC_CLEAR = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGE_RDA,
    ST_EDGE_WRA,
    ST_EDGE_WRB,
    ST_COL_ROW,
    ST_COL_MASK,
    ST_COL_SCAN,
    ST_COL_FIND1,
    ST_COL_FIND2,
    ST_COL_DONE
  } state_t;

endpackage

@@ rtl/ggc_ram.sv @@
`timescale 1ns / 1ps

module ggc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/greedy_graph_coloring_top.sv @@
`timescale 1ns / 1ps

// Channel  Direction  tdata (lowest bit first)            tuser
// in_      slave      vertex_a[5:0], vertex_b[11:6], pad   func[1:0]
// out_     master     vertex[5:0], color[11:6], pad        -
//
// An add-edge transaction steps through ST_EDGE_RDA, ST_EDGE_WRA and ST_EDGE_WRB
// before ready returns, a clear or an ignored transaction keeps ready high, and a
// colour transaction walks the colour memory in ST_COL_SCAN, one neighbour slot
// per cycle over its single read port. Reset is synchronous and active low; it
// empties the graph through per-row valid bits and marks every vertex uncoloured,
// so no clearing pass is needed. The input is not ready while an item is in work.
// A finished colour waits in the output register; only the next colour result
// stalls if the previous one has not yet been taken.
module greedy_graph_coloring_top
  import ggc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // vertex_a[5:0], vertex_b[11:6], zero pad
  input  logic [TUSER_W-1:0] in_tuser,   // func[1:0]
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata   // vertex[5:0], color[11:6], zero pad
);

  localparam int PAD_OUT = TDATA_W - 2 * FIELD_W;

  // Sequencer and captured request.
  state_t state_r, state_nxt;
  logic [FIELD_W-1:0] a_r, a_nxt;
  logic [FIELD_W-1:0] b_r, b_nxt;

  // Graph state kept in flops: row valid bits stand in for an emptied matrix row.
  logic [LIVE_VERTICES-1:0] row_valid_r, row_valid_nxt;
  logic [LIVE_VERTICES-1:0] color_valid_r, color_valid_nxt;
  logic                     row_ok_r;

  // Colour search datapath.
  logic [LIVE_VERTICES-1:0] nb_r, nb_nxt;
  logic [COLORS-1:0]        used_r, used_nxt;
  logic [VW-1:0]            cnt_r, cnt_nxt;
  logic [GROUPS-1:0]        grp_any_r, grp_any_nxt;
  logic [GIDX_W-1:0]        grp_idx_r [GROUPS];
  logic [GIDX_W-1:0]        grp_idx_nxt [GROUPS];
  logic [FIELD_W-1:0]       color_r, color_nxt;

  // Output register.
  logic               out_tvalid_r, out_tvalid_nxt;
  logic [FIELD_W-1:0] out_vertex_r, out_vertex_nxt;
  logic [FIELD_W-1:0] out_color_r, out_color_nxt;

  // Memory ports.
  logic                     adj_we;
  logic [VW-1:0]            adj_waddr, adj_raddr;
  logic [LIVE_VERTICES-1:0] adj_wdata, adj_rdata;
  logic                     col_we;
  logic [VW-1:0]            col_raddr;
  logic [FIELD_W-1:0]       col_rdata;

  // Decoded input transaction.
  logic               in_acc;
  logic [FIELD_W-1:0] in_a, in_b;
  logic               in_a_ok, in_b_ok;
  logic               out_room;

  logic [VW-1:0]            a_idx, b_idx;
  logic [LIVE_VERTICES-1:0] row_eff;
  logic [LIVE_VERTICES-1:0] one_live;
  logic [COLORS-1:0]        free_colors;

  assign in_a     = in_tdata[FIELD_W-1:0];
  assign in_b     = in_tdata[2*FIELD_W-1:FIELD_W];
  assign in_a_ok  = ({1'b0, in_a} < (FIELD_W + 1)'(LIVE_VERTICES));
  assign in_b_ok  = ({1'b0, in_b} < (FIELD_W + 1)'(LIVE_VERTICES));
  assign in_acc   = in_tvalid & in_tready;
  assign out_room = ~out_tvalid_r | out_tready;

  assign a_idx    = a_r[VW-1:0];
  assign b_idx    = b_r[VW-1:0];
  assign one_live = {{(LIVE_VERTICES - 1){1'b0}}, 1'b1};
  // A row that has not been written since the last clear reads as empty.
  assign row_eff  = adj_rdata & {LIVE_VERTICES{row_ok_r}};

  // Adjacency matrix, one row per vertex.
  ggc_ram #(
    .WIDTH (LIVE_VERTICES),
    .DEPTH (LIVE_VERTICES)
  ) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  // Colour per vertex; only entries marked coloured are ever used.
  ggc_ram #(
    .WIDTH (FIELD_W),
    .DEPTH (LIVE_VERTICES)
  ) u_col_ram (
    .clk   (clk),
    .we    (col_we),
    .waddr (a_idx),
    .wdata (color_r),
    .raddr (col_raddr),
    .rdata (col_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == FUNC_EDGE && in_a_ok && in_b_ok && in_a != in_b) begin
            state_nxt = ST_EDGE_RDA;
          end else if (in_tuser == FUNC_COLOR && in_a_ok) begin
            state_nxt = ST_COL_ROW;
          end
        end
      end
      ST_EDGE_RDA:  state_nxt = ST_EDGE_WRA;
      ST_EDGE_WRA:  state_nxt = ST_EDGE_WRB;
      ST_EDGE_WRB:  state_nxt = ST_IDLE;
      ST_COL_ROW:   state_nxt = ST_COL_MASK;
      ST_COL_MASK:  state_nxt = ST_COL_SCAN;
      ST_COL_SCAN: begin
        if (cnt_r == VW'(LIVE_VERTICES - 1)) begin
          state_nxt = ST_COL_FIND1;
        end
      end
      ST_COL_FIND1: state_nxt = ST_COL_FIND2;
      ST_COL_FIND2: state_nxt = ST_COL_DONE;
      ST_COL_DONE: begin
        if (out_room) begin
          state_nxt = ST_IDLE;
        end
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Handshake and memory control.
  always_comb begin
    in_tready = 1'b0;
    adj_we    = 1'b0;
    adj_waddr = a_idx;
    adj_wdata = row_eff | (one_live << a_idx);
    adj_raddr = a_idx;
    col_we    = 1'b0;
    col_raddr = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
      end
      ST_EDGE_WRA: begin
        // Row a comes back now; row b is fetched in the same cycle.
        adj_we    = 1'b1;
        adj_waddr = a_idx;
        adj_wdata = row_eff | (one_live << b_idx);
        adj_raddr = b_idx;
      end
      ST_EDGE_WRB: begin
        adj_we    = 1'b1;
        adj_waddr = b_idx;
        adj_wdata = row_eff | (one_live << a_idx);
      end
      ST_COL_SCAN: begin
        col_raddr = cnt_r + VW'(1);
      end
      ST_COL_DONE: begin
        col_we = out_room;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // Datapath next values.
  always_comb begin
    a_nxt           = a_r;
    b_nxt           = b_r;
    row_valid_nxt   = row_valid_r;
    color_valid_nxt = color_valid_r;
    nb_nxt          = nb_r;
    used_nxt        = used_r;
    cnt_nxt         = cnt_r;
    grp_any_nxt     = grp_any_r;
    grp_idx_nxt     = grp_idx_r;
    color_nxt       = color_r;
    out_tvalid_nxt  = out_tvalid_r & ~out_tready;
    out_vertex_nxt  = out_vertex_r;
    out_color_nxt   = out_color_r;
    // The top colour is never marked free-blocked, so the search saturates there.
    free_colors     = ~used_r;
    free_colors[COLORS-1] = 1'b1;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          a_nxt = in_a;
          b_nxt = in_b;
          if (in_tuser == FUNC_CLEAR) begin
            row_valid_nxt   = '0;
            color_valid_nxt = '0;
          end
        end
      end
      ST_EDGE_WRA: begin
        row_valid_nxt[a_idx] = 1'b1;
      end
      ST_EDGE_WRB: begin
        row_valid_nxt[b_idx] = 1'b1;
      end
      ST_COL_MASK: begin
        nb_nxt   = row_eff & color_valid_r;
        used_nxt = '0;
        cnt_nxt  = '0;
      end
      ST_COL_SCAN: begin
        if (nb_r[cnt_r]) begin
          used_nxt = used_r | ({{(COLORS - 1){1'b0}}, 1'b1} << col_rdata);
        end
        cnt_nxt = cnt_r + VW'(1);
      end
      ST_COL_FIND1: begin
        // First level: lowest free colour inside each group of eight.
        for (int g = 0; g < GROUPS; g++) begin
          grp_any_nxt[g] = |free_colors[g*GROUP_W +: GROUP_W];
          grp_idx_nxt[g] = '0;
          for (int j = GROUP_W - 1; j >= 0; j--) begin
            if (free_colors[g*GROUP_W + j]) begin
              grp_idx_nxt[g] = GIDX_W'(j);
            end
          end
        end
      end
      ST_COL_FIND2: begin
        // Second level: the lowest group that has a free colour.
        color_nxt = '0;
        for (int g = GROUPS - 1; g >= 0; g--) begin
          if (grp_any_r[g]) begin
            color_nxt = {GSEL_W'(g), grp_idx_r[g]};
          end
        end
      end
      ST_COL_DONE: begin
        if (out_room) begin
          color_valid_nxt[a_idx] = 1'b1;
          out_tvalid_nxt         = 1'b1;
          out_vertex_nxt         = a_r;
          out_color_nxt          = color_r;
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      row_valid_r   <= '0;
      color_valid_r <= '0;
      out_tvalid_r  <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      row_valid_r   <= row_valid_nxt;
      color_valid_r <= color_valid_nxt;
      out_tvalid_r  <= out_tvalid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    row_ok_r     <= row_valid_r[adj_raddr];
    nb_r         <= nb_nxt;
    used_r       <= used_nxt;
    cnt_r        <= cnt_nxt;
    grp_any_r    <= grp_any_nxt;
    grp_idx_r    <= grp_idx_nxt;
    color_r      <= color_nxt;
    out_vertex_r <= out_vertex_nxt;
    out_color_r  <= out_color_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{PAD_OUT{1'b0}}, out_color_r, out_vertex_r};

`ifndef SYNTHESIS
  // Finishing a colour with room at the output must present a result next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COL_DONE && out_room) |=> out_tvalid_r)
    else $error("colour result not presented");

  // The colour search begins only after the last neighbour slot has been walked.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COL_FIND1) |->
      ($past(state_r) == ST_COL_SCAN && $past(cnt_r) == VW'(LIVE_VERTICES - 1)))
    else $error("neighbour walk cut short");

  // Coloured vertices stay coloured unless a clear transaction is accepted.
  assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !(in_acc && in_tuser == FUNC_CLEAR)) |=>
      ((color_valid_r & $past(color_valid_r)) == $past(color_valid_r)))
    else $error("vertex lost its colour without a clear");
`endif

endmodule
